@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, prop)
`endif
`endif

@@ src/xfr_pkg.sv @@
// ---------------------------------------------------------------------------
// xfr_pkg
// Constants, codes and helpers of the XMODEM flash receiver.
// ---------------------------------------------------------------------------
package xfr_pkg;

   localparam int PACKET_BYTES_DEF = 128;
   localparam int PAGE_BYTES_DEF   = 128;

   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 32;
   localparam int FP_W    = 17;
   localparam int CHK_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] SOH_CODE   = 8'h01;
   localparam logic [BYTE_W-1:0] EOT_CODE   = 8'h04;
   localparam logic [BYTE_W-1:0] ACK_CODE   = 8'h06;
   localparam logic [BYTE_W-1:0] NACK_CODE  = 8'h15;
   localparam logic [BYTE_W-1:0] READY_CODE = 8'h43;

   localparam logic [CHK_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CHK_W-1:0] CRC_MSB  = 16'h8000;

   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CRC_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_BYTES  = 2'd2;

   localparam logic [FP_W-1:0] FLASH_BYTES_RST = 17'd8192;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX    = 2'd0,
      KIND_ERASE = 2'd1,
      KIND_FILL  = 2'd2,
      KIND_WRITE = 2'd3
   } kind_type;

   function automatic logic [CHK_W-1:0] crc16_byte(input logic [CHK_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CHK_W-1:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if ((acc & CRC_MSB) != '0) begin
            acc = {acc[CHK_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[CHK_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

@@ src/xmodem_flash_receiver.sv @@
// ---------------------------------------------------------------------------
// xmodem_flash_receiver
// XMODEM receiver that checks 128-byte packets and emits flash commands.
// ---------------------------------------------------------------------------
// Requests carry one UART byte (req_cmd low) or a one-second silence tick
// (req_cmd high). Responses carry either a byte to transmit or a flash
// command (page erase, 32-bit fill, page write); rsp_last marks the final
// response caused by a request. Both channels move a request when valid is
// high and stall is low.
// A request that causes a single reply byte passes through the reply state,
// which waits out any output stall. The final check byte of a good packet
// runs the flash sequencer: per page one erase, PAGE_BYTES/4 fills and one
// write, then ACK or NACK. Each fill first passes through a read state,
// since the packet buffer has one read port with registered data.
// req_stall is high while the sequencer runs; a stalled response holds in
// the output register and the sequencer waits on it.
// Synchronous reset returns the protocol to waiting for the first SOH,
// restores the register defaults and empties the output register. The
// packet buffer is not cleared; it is always written before it is read.
// ---------------------------------------------------------------------------
module xmodem_flash_receiver #(
   parameter int PACKET_BYTES = xfr_pkg::PACKET_BYTES_DEF,
   parameter int PAGE_BYTES   = xfr_pkg::PAGE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [xfr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [xfr_pkg::KIND_W-1:0]      rsp_kind,
   output logic [xfr_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic [xfr_pkg::ADDR_W-1:0]      rsp_flash_address,
   output logic [xfr_pkg::DATA_W-1:0]      rsp_fill_data,
   output logic                            rsp_done_res,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [xfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xfr_pkg::FP_W-1:0]        csr_wdata
);
   import xfr_pkg::*;
   `include "assert_macros.svh"

   localparam int WORDS      = PACKET_BYTES / 4;
   localparam int WADDR_W    = $clog2(WORDS);
   localparam int CNT_W      = $clog2(PACKET_BYTES);
   localparam int PAGE_WORDS = PAGE_BYTES / 4;
   localparam int OFF_W      = $clog2(PAGE_WORDS);

   typedef enum logic [3:0] {
      PH_IDLE, PH_BLK, PH_NBLK, PH_DATA, PH_CHK1,
      PH_CHK2, PH_CHK2_BAD, PH_SYNC, PH_DRAIN, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      S_ACCEPT, S_REPLY, S_ERASE, S_FILLRD, S_FILL, S_WRITE
   } seq_type;

   logic [DATA_W-1:0] store_mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   phase_type           phase_ff, phase_in;
   seq_type             seq_ff, seq_in;
   logic [BYTE_W-1:0]   block_ff, block_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [CHK_W-1:0]    crc_ff, crc_in;
   logic [CHK_W-1:0]    rcheck_ff, rcheck_in;
   logic [FP_W-1:0]     fp_ff, fp_in;
   logic [WADDR_W-1:0]  wptr_ff, wptr_in;
   logic [BYTE_W-1:0]   reply_tx_ff, reply_tx_in;
   logic                reply_done_ff, reply_done_in;
   logic                crc_mode_ff, crc_mode_in;
   logic                check_en_ff, check_en_in;
   logic [FP_W-1:0]     flash_bytes_ff, flash_bytes_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]   rsp_tx_ff, rsp_tx_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_done_ff, rsp_done_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                tick;
   logic                slot_free;
   logic                mem_we;
   logic                page_fits;
   logic [OFF_W+1:0]    off_bytes;
   logic [FP_W-1:0]     fill_addr;

   assign req_stall = (seq_ff != S_ACCEPT);
   assign accept    = req_valid && !req_stall;
   assign tick      = (req_cmd == CMD_TICK);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign mem_we    = accept && (phase_ff == PH_DATA) && !tick;
   assign off_bytes = {wptr_ff[OFF_W-1:0], 2'b00};
   assign fill_addr = fp_ff + FP_W'(off_bytes);
   assign page_fits = ({1'b0, fp_ff} + (FP_W+1)'(PAGE_BYTES)) <= {1'b0, flash_bytes_ff};

   always_comb begin
      logic             fin;
      logic             fin_bad;
      logic [CHK_W-1:0] fin_rc;
      logic [CHK_W-1:0] fin_acc;

      phase_in       = phase_ff;
      seq_in         = seq_ff;
      block_in       = block_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      crc_in         = crc_ff;
      rcheck_in      = rcheck_ff;
      fp_in          = fp_ff;
      wptr_in        = wptr_ff;
      reply_tx_in    = reply_tx_ff;
      reply_done_in  = reply_done_ff;
      crc_mode_in    = crc_mode_ff;
      check_en_in    = check_en_ff;
      flash_bytes_in = flash_bytes_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_tx_in      = rsp_tx_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_last_in    = rsp_last_ff;
      fin            = 1'b0;
      fin_bad        = 1'b0;
      fin_rc         = rcheck_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_CRC_MODE:     crc_mode_in    = csr_wdata[0];
            CSR_CHECK_ENABLE: check_en_in    = csr_wdata[0];
            CSR_FLASH_BYTES:  flash_bytes_in = csr_wdata;
            default: ;
         endcase
      end

      case (seq_ff)
         S_ACCEPT: begin
            if (accept) begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (!tick && req_rx_byte == SOH_CODE) begin
                        phase_in = PH_BLK;
                     end else begin
                        reply_tx_in   = READY_CODE;
                        reply_done_in = 1'b0;
                        seq_in        = S_REPLY;
                     end
                  end
                  PH_BLK: begin
                     phase_in = (!tick && req_rx_byte == block_ff) ? PH_NBLK : PH_SYNC;
                  end
                  PH_NBLK: begin
                     if (!tick && ~req_rx_byte == block_ff) begin
                        count_in = '0;
                        sum_in   = '0;
                        crc_in   = '0;
                        phase_in = PH_DATA;
                     end else begin
                        phase_in = PH_SYNC;
                     end
                  end
                  PH_DATA: begin
                     if (tick) begin
                        phase_in = PH_SYNC;
                     end else begin
                        sum_in   = sum_ff + req_rx_byte;
                        crc_in   = crc16_byte(crc_ff, req_rx_byte);
                        count_in = count_ff + 1'b1;
                        if (count_ff == CNT_W'(PACKET_BYTES - 1)) begin
                           phase_in = PH_CHK1;
                        end
                     end
                  end
                  PH_CHK1: begin
                     if (crc_mode_ff) begin
                        rcheck_in = tick ? '0 : {req_rx_byte, 8'h00};
                        phase_in  = tick ? PH_CHK2_BAD : PH_CHK2;
                     end else begin
                        fin_rc    = tick ? '0 : {8'h00, req_rx_byte};
                        rcheck_in = fin_rc;
                        fin       = 1'b1;
                        fin_bad   = tick;
                     end
                  end
                  PH_CHK2, PH_CHK2_BAD: begin
                     fin_rc    = tick ? rcheck_ff : {rcheck_ff[CHK_W-1:8], req_rx_byte};
                     rcheck_in = fin_rc;
                     fin       = 1'b1;
                     fin_bad   = tick || (phase_ff == PH_CHK2_BAD);
                  end
                  PH_SYNC: begin
                     if (!tick && req_rx_byte == SOH_CODE) begin
                        phase_in = PH_BLK;
                     end else if (!tick && req_rx_byte == EOT_CODE) begin
                        reply_tx_in   = ACK_CODE;
                        reply_done_in = 1'b1;
                        seq_in        = S_REPLY;
                        phase_in      = PH_DONE;
                     end else begin
                        phase_in = PH_DRAIN;
                     end
                  end
                  PH_DRAIN: begin
                     if (tick) begin
                        reply_tx_in   = NACK_CODE;
                        reply_done_in = 1'b0;
                        seq_in        = S_REPLY;
                        phase_in      = PH_SYNC;
                     end
                  end
                  PH_DONE: ;
                  default: phase_in = PH_SYNC;
               endcase
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TX;
               rsp_tx_in    = reply_tx_ff;
               rsp_addr_in  = '0;
               rsp_data_in  = '0;
               rsp_done_in  = reply_done_ff;
               rsp_last_in  = 1'b1;
               seq_in       = S_ACCEPT;
            end
         end
         S_ERASE: begin
            if (!page_fits) begin
               reply_tx_in   = NACK_CODE;
               reply_done_in = 1'b0;
               seq_in        = S_REPLY;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ERASE;
               rsp_tx_in    = '0;
               rsp_addr_in  = fp_ff[ADDR_W-1:0];
               rsp_data_in  = '0;
               rsp_done_in  = 1'b0;
               rsp_last_in  = 1'b0;
               seq_in       = S_FILLRD;
            end
         end
         S_FILLRD: seq_in = S_FILL;
         S_FILL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FILL;
               rsp_tx_in    = '0;
               rsp_addr_in  = fill_addr[ADDR_W-1:0];
               rsp_data_in  = rd_data_ff;
               rsp_done_in  = 1'b0;
               rsp_last_in  = 1'b0;
               wptr_in      = wptr_ff + 1'b1;
               seq_in       = (wptr_ff[OFF_W-1:0] == OFF_W'(PAGE_WORDS - 1)) ?
                              S_WRITE : S_FILLRD;
            end
         end
         S_WRITE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WRITE;
               rsp_tx_in    = '0;
               rsp_addr_in  = fp_ff[ADDR_W-1:0];
               rsp_data_in  = '0;
               rsp_done_in  = 1'b0;
               rsp_last_in  = 1'b0;
               fp_in        = fp_ff + FP_W'(PAGE_BYTES);
               if (wptr_ff == '0) begin
                  reply_tx_in   = ACK_CODE;
                  reply_done_in = 1'b0;
                  seq_in        = S_REPLY;
               end else begin
                  seq_in = S_ERASE;
               end
            end
         end
         default: seq_in = S_ACCEPT;
      endcase

      fin_acc = crc_mode_ff ? crc_ff : {8'h00, sum_ff};
      if (fin) begin
         phase_in = PH_SYNC;
         if (!check_en_ff || (!fin_bad && fin_acc == fin_rc)) begin
            block_in = block_ff + 1'b1;
            wptr_in  = '0;
            seq_in   = S_ERASE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[CNT_W-1:2]][count_ff[1:0]*8 +: 8] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[wptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         seq_ff         <= S_ACCEPT;
         block_ff       <= 8'd1;
         count_ff       <= '0;
         sum_ff         <= '0;
         crc_ff         <= '0;
         rcheck_ff      <= '0;
         fp_ff          <= '0;
         wptr_ff        <= '0;
         crc_mode_ff    <= 1'b0;
         check_en_ff    <= 1'b1;
         flash_bytes_ff <= FLASH_BYTES_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         seq_ff         <= seq_in;
         block_ff       <= block_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         crc_ff         <= crc_in;
         rcheck_ff      <= rcheck_in;
         fp_ff          <= fp_in;
         wptr_ff        <= wptr_in;
         crc_mode_ff    <= crc_mode_in;
         check_en_ff    <= check_en_in;
         flash_bytes_ff <= flash_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      reply_tx_ff   <= reply_tx_in;
      reply_done_ff <= reply_done_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tx_ff     <= rsp_tx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_tx_byte       = rsp_tx_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_fill_data     = rsp_data_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_CLK(a_busy_phase, clock, reset, (seq_ff != S_ACCEPT) |-> (phase_ff == PH_IDLE || phase_ff == PH_SYNC || phase_ff == PH_DONE))
   `ASSERT_CLK(a_load_busy, clock, reset, $rose(rsp_valid_ff) |-> $past(seq_ff != S_ACCEPT))
   `ASSERT_CLK(a_addr_align, clock, reset, rsp_valid_ff |-> (rsp_addr_ff[1:0] == 2'b00))
   `ASSERT_NEVER(a_done_ack, clock, reset, rsp_valid_ff && rsp_done_ff && (rsp_tx_ff != ACK_CODE || !rsp_last_ff))

endmodule

@@ dv/tb_xmodem_flash_receiver.sv @@
// ---------------------------------------------------------------------------
// tb_xmodem_flash_receiver
// Self-checking testbench of the XMODEM flash receiver.
// ---------------------------------------------------------------------------
// A generator builds request streams (well-formed packets with random data,
// packets broken at every compared field, line noise and silence ticks) and
// queues them for a bursty driver. Every accepted request runs through a
// cycle-free model of the receiver protocol, which queues the responses the
// block owes: ready bytes, flash erase/fill/write commands and ACK or NACK.
// A monitor compares every accepted response field by field against the
// oldest owed one, under a randomly stalling receiver. The generator keeps a
// second copy of the model to know the protocol phase of each request, so it
// can resync between sequences and keep EOT back until the last phase.
// Register settings change only while the block is idle, including once in
// the middle of a packet's data.
// ---------------------------------------------------------------------------
module tb_xmodem_flash_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import xfr_pkg::*;

   localparam int PACKET_BYTES   = PACKET_BYTES_DEF;
   localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 240;
   localparam logic CMD_RX       = ~CMD_TICK;

   typedef enum logic [3:0] {
      PH_IDLE, PH_BLK, PH_NBLK, PH_DATA, PH_CHK1, PH_CHK2, PH_CHK2_BAD,
      PH_SYNC, PH_DRAIN, PH_DONE
   } rx_phase_t;

   typedef enum int {
      FLT_NONE, FLT_BAD_BLK, FLT_BAD_NBLK, FLT_TICK_BLK, FLT_TICK_NBLK,
      FLT_TICK_DATA, FLT_BAD_CHK, FLT_TICK_CHK1, FLT_TICK_CHK2
   } fault_t;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] rx;
   } req_item_t;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] tx_byte;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] fill;
      logic              done;
      logic              last;
   } rsp_item_t;

   typedef struct packed {
      logic                              crc_mode;
      logic                              check_en;
      logic [FP_W-1:0]                   flash_bytes;
      rx_phase_t                         phase;
      logic [BYTE_W-1:0]                 blk;
      logic [7:0]                        cnt;
      logic [CHK_W-1:0]                  rcv_chk;
      logic [FP_W-1:0]                   fptr;
      logic [PACKET_BYTES-1:0][BYTE_W-1:0] pkt;
   } rx_state_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = 1'b0;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [BYTE_W-1:0]    rsp_tx_byte;
   logic [ADDR_W-1:0]    rsp_flash_address;
   logic [DATA_W-1:0]    rsp_fill_data;
   logic                 rsp_done_res;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CRC_MODE;
   logic [FP_W-1:0]      csr_wdata = '0;

   req_item_t req_pend_q[$];
   req_item_t pkt_q[$];
   rsp_item_t step_q[$];
   rsp_item_t rsp_due_q[$];

   rx_state_t chk_st;
   rx_state_t gen_st;
   req_item_t nxt_req;
   rsp_item_t due;
   int        burst_left = 1;
   int        gap_left = 0;
   int        stall_mode = 0;
   int        stall_cnt = 0;
   int        idle_cnt = 0;
   int        err_cnt = 0;
   int        sent = 0;
   logic      allow_done = 1'b0;

   xmodem_flash_receiver #(
      .PACKET_BYTES(PACKET_BYTES),
      .PAGE_BYTES  (PAGE_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_flash_address(rsp_flash_address),
      .rsp_fill_data    (rsp_fill_data),
      .rsp_done_res     (rsp_done_res),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CHK_W-1:0] packet_check(
      input logic [PACKET_BYTES-1:0][BYTE_W-1:0] d, input logic crc);
      logic [CHK_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < PACKET_BYTES; i++) begin
         if (crc) begin
            acc = acc ^ {d[i], 8'h00};
            for (int k = 0; k < 8; k++) begin
               if (acc[CHK_W-1]) begin
                  acc = {acc[CHK_W-2:0], 1'b0} ^ CRC_POLY;
               end else begin
                  acc = {acc[CHK_W-2:0], 1'b0};
               end
            end
         end else begin
            acc = {8'h00, 8'(acc[7:0] + d[i])};
         end
      end
      return acc;
   endfunction

   function automatic void add_rsp(input kind_type k, input logic [BYTE_W-1:0] tx,
                                   input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                                   input logic done);
      rsp_item_t r;
      r.kind    = k;
      r.tx_byte = tx;
      r.addr    = a;
      r.fill    = d;
      r.done    = done;
      r.last    = 1'b0;
      step_q.push_back(r);
   endfunction

   function automatic void close_packet(inout rx_state_t st, input logic mism);
      logic [CHK_W-1:0]  calc;
      logic              fits;
      logic [FP_W-1:0]   a17;
      logic [DATA_W-1:0] w;
      int                base;
      calc     = packet_check(st.pkt, st.crc_mode);
      st.phase = PH_SYNC;
      if (st.check_en && (mism || calc != st.rcv_chk)) begin
         return;
      end
      fits = 1'b1;
      for (int pg = 0; pg < PACKET_BYTES / PAGE_BYTES; pg++) begin
         if (int'(st.flash_bytes) < PAGE_BYTES ||
             int'(st.fptr) > int'(st.flash_bytes) - PAGE_BYTES) begin
            fits = 1'b0;
            break;
         end
         add_rsp(KIND_ERASE, '0, st.fptr[ADDR_W-1:0], '0, 1'b0);
         for (int off = 0; off + 4 <= PAGE_BYTES; off += 4) begin
            base = pg * PAGE_BYTES + off;
            w    = {st.pkt[base+3], st.pkt[base+2], st.pkt[base+1], st.pkt[base]};
            a17  = st.fptr + FP_W'(off);
            add_rsp(KIND_FILL, '0, a17[ADDR_W-1:0], w, 1'b0);
         end
         add_rsp(KIND_WRITE, '0, st.fptr[ADDR_W-1:0], '0, 1'b0);
         st.fptr = st.fptr + FP_W'(PAGE_BYTES);
      end
      add_rsp(KIND_TX, fits ? ACK_CODE : NACK_CODE, '0, '0, 1'b0);
      st.blk = st.blk + 8'd1;
   endfunction

   function automatic void receiver_step(inout rx_state_t st, input logic cmd,
                                         input logic [BYTE_W-1:0] b);
      logic      tick;
      rsp_item_t r;
      tick = (cmd == CMD_TICK);
      step_q.delete();
      case (st.phase)
         PH_IDLE: begin
            if (!tick && b == SOH_CODE) begin
               st.phase = PH_BLK;
            end else begin
               add_rsp(KIND_TX, READY_CODE, '0, '0, 1'b0);
            end
         end
         PH_BLK: begin
            st.phase = (!tick && b == st.blk) ? PH_NBLK : PH_SYNC;
         end
         PH_NBLK: begin
            if (!tick && BYTE_W'(~b) == st.blk) begin
               st.cnt   = '0;
               st.phase = PH_DATA;
            end else begin
               st.phase = PH_SYNC;
            end
         end
         PH_DATA: begin
            if (tick) begin
               st.phase = PH_SYNC;
            end else begin
               st.pkt[st.cnt % PACKET_BYTES] = b;
               st.cnt = st.cnt + 8'd1;
               if (int'(st.cnt) >= PACKET_BYTES) begin
                  st.phase = PH_CHK1;
               end
            end
         end
         PH_CHK1: begin
            if (st.crc_mode) begin
               st.rcv_chk = tick ? '0 : {b, 8'h00};
               st.phase   = tick ? PH_CHK2_BAD : PH_CHK2;
            end else begin
               st.rcv_chk = tick ? '0 : {8'h00, b};
               close_packet(st, tick);
            end
         end
         PH_CHK2, PH_CHK2_BAD: begin
            if (!tick) begin
               st.rcv_chk[7:0] = b;
            end
            close_packet(st, tick || st.phase == PH_CHK2_BAD);
         end
         PH_SYNC: begin
            if (!tick && b == SOH_CODE) begin
               st.phase = PH_BLK;
            end else if (!tick && b == EOT_CODE) begin
               add_rsp(KIND_TX, ACK_CODE, '0, '0, 1'b1);
               st.phase = PH_DONE;
            end else begin
               st.phase = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (tick) begin
               add_rsp(KIND_TX, NACK_CODE, '0, '0, 1'b0);
               st.phase = PH_SYNC;
            end
         end
         PH_DONE: begin
         end
         default: begin
            st.phase = PH_SYNC;
         end
      endcase
      if (step_q.size() != 0) begin
         r = step_q.pop_back();
         r.last = 1'b1;
         step_q.push_back(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            receiver_step(chk_st, req_cmd, req_rx_byte);
            foreach (step_q[i]) begin
               rsp_due_q.push_back(step_q[i]);
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (req_pend_q.size() != 0) begin
               nxt_req     = req_pend_q.pop_front();
               req_valid   <= 1'b1;
               req_cmd     <= nxt_req.cmd;
               req_rx_byte <= nxt_req.rx;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         stall_cnt  <= 0;
      end else begin
         if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_cnt  <= $urandom_range(20, 300);
         end else begin
            stall_cnt <= stall_cnt - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due_q.size() == 0) begin
            $error("unexpected response: kind %0d tx_byte %h addr %h",
                   rsp_kind, rsp_tx_byte, rsp_flash_address);
            err_cnt++;
         end else begin
            due = rsp_due_q.pop_front();
            if (rsp_kind !== due.kind) begin
               $error("kind: expected %0d, got %0d", due.kind, rsp_kind);
               err_cnt++;
            end
            if (rsp_tx_byte !== due.tx_byte) begin
               $error("tx_byte: expected %h, got %h", due.tx_byte, rsp_tx_byte);
               err_cnt++;
            end
            if (rsp_flash_address !== due.addr) begin
               $error("flash_address: expected %h, got %h", due.addr, rsp_flash_address);
               err_cnt++;
            end
            if (rsp_fill_data !== due.fill) begin
               $error("fill_data: expected %h, got %h", due.fill, rsp_fill_data);
               err_cnt++;
            end
            if (rsp_done_res !== due.done) begin
               $error("done_res: expected %0d, got %0d", due.done, rsp_done_res);
               err_cnt++;
            end
            if (rsp_last !== due.last) begin
               $error("last: expected %0d, got %0d", due.last, rsp_last);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cnt <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("** xmodem_flash_receiver: FAILED **");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   task automatic send(input logic cmd, input logic [BYTE_W-1:0] b);
      req_item_t it;
      if (cmd == CMD_RX && b == EOT_CODE && gen_st.phase == PH_SYNC && !allow_done) begin
         b = b ^ 8'h80;
      end
      it.cmd = cmd;
      it.rx  = b;
      req_pend_q.push_back(it);
      receiver_step(gen_st, cmd, b);
      sent++;
   endtask

   task automatic send_tick();
      send(CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic resync();
      while (gen_st.phase != PH_SYNC && gen_st.phase != PH_IDLE) begin
         send_tick();
      end
   endtask

   task automatic build_packet(input fault_t f, input logic chk_crc);
      logic [PACKET_BYTES-1:0][BYTE_W-1:0] d;
      logic [CHK_W-1:0]  c;
      logic [BYTE_W-1:0] blk;
      int                style;
      int                cut;
      pkt_q.delete();
      blk   = gen_st.blk;
      style = $urandom_range(0, 9);
      for (int k = 0; k < PACKET_BYTES; k++) begin
         d[k] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      c = packet_check(d, chk_crc);
      if (f == FLT_BAD_CHK) begin
         c = c ^ (chk_crc ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255)));
      end
      pkt_q.push_back({CMD_RX, SOH_CODE});
      if (f == FLT_TICK_BLK) begin
         pkt_q.push_back({CMD_TICK, 8'($urandom_range(0, 255))});
      end else if (f == FLT_BAD_BLK) begin
         pkt_q.push_back({CMD_RX, 8'(blk ^ 8'($urandom_range(1, 255)))});
      end else begin
         pkt_q.push_back({CMD_RX, blk});
      end
      if (f == FLT_TICK_NBLK) begin
         pkt_q.push_back({CMD_TICK, 8'($urandom_range(0, 255))});
      end else if (f == FLT_BAD_NBLK) begin
         pkt_q.push_back({CMD_RX, 8'(~blk ^ 8'($urandom_range(1, 255)))});
      end else begin
         pkt_q.push_back({CMD_RX, 8'(~blk)});
      end
      cut = (f == FLT_TICK_DATA) ? $urandom_range(0, PACKET_BYTES - 1) : PACKET_BYTES;
      for (int k = 0; k < cut; k++) begin
         pkt_q.push_back({CMD_RX, d[k]});
      end
      if (f == FLT_TICK_DATA) begin
         pkt_q.push_back({CMD_TICK, 8'($urandom_range(0, 255))});
      end else if (chk_crc) begin
         pkt_q.push_back((f == FLT_TICK_CHK1) ? {CMD_TICK, 8'($urandom_range(0, 255))} :
                                               {CMD_RX, c[15:8]});
         pkt_q.push_back((f == FLT_TICK_CHK2) ? {CMD_TICK, 8'($urandom_range(0, 255))} :
                                               {CMD_RX, c[7:0]});
      end else begin
         pkt_q.push_back((f == FLT_TICK_CHK1 || f == FLT_TICK_CHK2) ?
                         {CMD_TICK, 8'($urandom_range(0, 255))} : {CMD_RX, c[7:0]});
      end
   endtask

   task automatic flush_packet(input int n);
      req_item_t it;
      while (n > 0 && pkt_q.size() != 0) begin
         it = pkt_q.pop_front();
         send(it.cmd, it.rx);
         n--;
      end
   endtask

   task automatic random_phase(input int budget);
      int start;
      int dice;
      start = sent;
      while (sent - start < budget) begin
         resync();
         dice = $urandom_range(0, 99);
         if (dice < 60) begin
            build_packet(FLT_NONE, gen_st.crc_mode);
            flush_packet(PACKET_BYTES + 8);
         end else if (dice < 88) begin
            build_packet(fault_t'($urandom_range(FLT_BAD_BLK, FLT_TICK_CHK2)), gen_st.crc_mode);
            flush_packet(PACKET_BYTES + 8);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_tick();
               end else begin
                  send(CMD_RX, 8'($urandom_range(0, 255)));
               end
            end
         end
      end
   endtask

   task automatic wait_idle();
      while (req_pend_q.size() != 0 || req_valid || rsp_due_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FP_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CRC_MODE: begin
            chk_st.crc_mode = val[0];
            gen_st.crc_mode = val[0];
         end
         CSR_CHECK_ENABLE: begin
            chk_st.check_en = val[0];
            gen_st.check_en = val[0];
         end
         CSR_FLASH_BYTES: begin
            chk_st.flash_bytes = val;
            gen_st.flash_bytes = val;
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      chk_st.crc_mode    = 1'b0;
      chk_st.check_en    = 1'b1;
      chk_st.flash_bytes = FLASH_BYTES_RST;
      chk_st.phase       = PH_IDLE;
      chk_st.blk         = 8'd1;
      chk_st.cnt         = '0;
      chk_st.rcv_chk     = '0;
      chk_st.fptr        = '0;
      chk_st.pkt         = '0;
      gen_st             = chk_st;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(CMD_TICK, 8'h00);
      send(CMD_RX, 8'h00);
      send(CMD_RX, 8'hFF);
      send(CMD_RX, EOT_CODE);
      send(CMD_RX, READY_CODE);
      send(CMD_RX, SOH_CODE);
      send(CMD_TICK, 8'hFF);
      send(CMD_RX, 8'h55);
      send(CMD_RX, SOH_CODE);
      send(CMD_TICK, 8'h00);
      send(CMD_RX, SOH_CODE);
      send(CMD_RX, 8'h01);
      send(CMD_RX, 8'h00);
      send(CMD_RX, SOH_CODE);
      send(CMD_RX, 8'h02);
      send(CMD_RX, SOH_CODE);
      send(CMD_RX, 8'h01);
      send(CMD_TICK, 8'h00);
      send(CMD_RX, SOH_CODE);
      send(CMD_RX, 8'h01);
      send(CMD_RX, 8'hFE);
      send(CMD_RX, 8'h00);
      send(CMD_RX, 8'hFF);
      send(CMD_RX, 8'hA5);
      send(CMD_TICK, 8'h5A);
      send_tick();
      send_tick();

      random_phase(PHASE_ITEMS);
      wait_idle();

      write_reg(CSR_CRC_MODE, 17'd1);
      random_phase(PHASE_ITEMS);
      wait_idle();

      // switch to the sum check in the middle of a packet's data
      resync();
      build_packet(FLT_NONE, 1'b0);
      flush_packet(70);
      wait_idle();
      write_reg(CSR_CRC_MODE, 17'd0);
      flush_packet(PACKET_BYTES + 8);
      wait_idle();

      write_reg(CSR_CHECK_ENABLE, 17'd0);
      random_phase(PHASE_ITEMS);
      wait_idle();

      write_reg(CSR_CRC_MODE, 17'd1);
      write_reg(CSR_FLASH_BYTES, 17'd65536);
      random_phase(PHASE_ITEMS);
      wait_idle();

      write_reg(CSR_CHECK_ENABLE, 17'd1);
      write_reg(CSR_FLASH_BYTES, FP_W'(gen_st.fptr + FP_W'(PAGE_BYTES) + 17'd77));
      random_phase(PHASE_ITEMS);
      wait_idle();

      write_reg(CSR_CRC_MODE, 17'd0);
      write_reg(CSR_FLASH_BYTES, 17'd0);
      random_phase(PHASE_ITEMS / 2);

      resync();
      allow_done = 1'b1;
      send(CMD_RX, EOT_CODE);
      send_tick();
      send(CMD_RX, SOH_CODE);
      send(CMD_RX, READY_CODE);
      send(CMD_RX, EOT_CODE);
      wait_idle();

      if (err_cnt == 0 && rsp_due_q.size() == 0) begin
         $display("** xmodem_flash_receiver: PASSED **");
      end else begin
         $display("** xmodem_flash_receiver: FAILED **");
      end
      $finish;
   end

endmodule
